FILE: rtl/cdd_pkg.sv
// ----------------------------------------------------------------------------
// cdd_pkg: shared types and constants of the calendar date unit
// Microcode opcodes, jump conditions, control word layout, the microcode
// program itself and the month length table.
// ----------------------------------------------------------------------------
package cdd_pkg;

  // field widths
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int DIFF_W   = 23;
  localparam int ORDER_W  = 2;
  localparam int SERIAL_W = 22;
  localparam int PC_W     = 5;
  localparam int Q_W      = 7;
  localparam int RECIP_W  = 13;

  // calendar constants
  localparam int YEAR_MAX      = 9999;
  localparam int MONTHS        = 12;
  localparam int DAYS_400      = 146097;
  localparam int DAYS_100      = 36524;
  localparam int DAYS_4        = 1461;
  localparam int DAYS_1        = 365;
  localparam int SERIAL_END    = 3652059;
  localparam int YEARS_400     = 400;
  localparam int YEARS_100     = 100;
  localparam int YEARS_4       = 4;
  localparam int FEB_LEAP_DAYS = 29;
  localparam int FEB_DAYS      = 28;
  localparam int SHORT_DAYS    = 30;
  localparam int LONG_DAYS     = 31;

  // year / 100 as (year * RECIP_100) >> RECIP_SHIFT, exact below 10000
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;

  // three-way order codes
  localparam logic [ORDER_W-1:0] ORDER_LT = 2'd0;
  localparam logic [ORDER_W-1:0] ORDER_EQ = 2'd1;
  localparam logic [ORDER_W-1:0] ORDER_GT = 2'd2;

  // entry points of the program
  localparam logic [PC_W-1:0] PC_DIFF = 5'd21;
  localparam logic [PC_W-1:0] PC_ERR  = 5'd31;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LD_BASE,
    OP_LD_OTHER,
    OP_QDIV,
    OP_LEAP,
    OP_MUL365,
    OP_ADDQ,
    OP_MADD,
    OP_DADD,
    OP_ADDOFF,
    OP_INITY,
    OP_SUB400,
    OP_SUB100,
    OP_SUB4,
    OP_CLRK,
    OP_SUB1,
    OP_MSUB,
    OP_SAVE,
    OP_SUBS0,
    OP_FIN_DATE,
    OP_FIN_DIFF,
    OP_FIN_ERR
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_BAD,
    C_MDONE,
    C_DIFF,
    C_RANGE,
    C_LT400,
    C_LT100,
    C_LT4,
    C_LT1,
    C_LTMON
  } cond_t;

  // one microcode word: op runs when cond is false, else jump to target
  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            loop;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    logic exec;
    op_t  op;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic bad;
    logic mdone;
    logic diff;
    logic range_err;
    logic lt400;
    logic lt100;
    logic lt4;
    logic lt1;
    logic ltmon;
  } flags_t;

  // latched request without the offset
  typedef struct packed {
    logic               req_type;
    logic [YEAR_W-1:0]  base_year;
    logic [MONTH_W-1:0] base_month;
    logic [DAY_W-1:0]   base_day;
    logic [YEAR_W-1:0]  other_year;
    logic [MONTH_W-1:0] other_month;
    logic [DAY_W-1:0]   other_day;
  } req_t;

  // datapath results
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [DIFF_W-1:0]  diff;
  } res_t;

  function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                  input logic [MONTH_W-1:0] month);
    logic [DAY_W-1:0] n;
    unique case (month)
      4'd2: begin
        n = leap ? DAY_W'(FEB_LEAP_DAYS) : DAY_W'(FEB_DAYS);
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        n = DAY_W'(SHORT_DAYS);
      end
      default: begin
        n = DAY_W'(LONG_DAYS);
      end
    endcase
    return n;
  endfunction

  function automatic uword_t mk(input op_t op, input cond_t cond,
                                input logic [PC_W-1:0] target, input logic loop);
    uword_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.loop   = loop;
    return w;
  endfunction

  // microcode program
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      // operand check, serial number of the base date
      5'd0:  w = mk(OP_NOP,      C_BAD,   PC_ERR, 1'b0);
      5'd1:  w = mk(OP_LD_BASE,  C_NEVER, 5'd0,   1'b0);
      5'd2:  w = mk(OP_QDIV,     C_NEVER, 5'd0,   1'b0);
      5'd3:  w = mk(OP_LEAP,     C_NEVER, 5'd0,   1'b0);
      5'd4:  w = mk(OP_MUL365,   C_NEVER, 5'd0,   1'b0);
      5'd5:  w = mk(OP_ADDQ,     C_NEVER, 5'd0,   1'b0);
      5'd6:  w = mk(OP_MADD,     C_MDONE, 5'd7,   1'b1);
      5'd7:  w = mk(OP_DADD,     C_NEVER, 5'd0,   1'b0);
      5'd8:  w = mk(OP_NOP,      C_DIFF,  PC_DIFF, 1'b0);
      // shift: add offset, range check, split back into a date
      5'd9:  w = mk(OP_ADDOFF,   C_NEVER, 5'd0,   1'b0);
      5'd10: w = mk(OP_NOP,      C_RANGE, PC_ERR, 1'b0);
      5'd11: w = mk(OP_INITY,    C_NEVER, 5'd0,   1'b0);
      5'd12: w = mk(OP_SUB400,   C_LT400, 5'd13,  1'b1);
      5'd13: w = mk(OP_SUB100,   C_LT100, 5'd14,  1'b1);
      5'd14: w = mk(OP_SUB4,     C_LT4,   5'd15,  1'b1);
      5'd15: w = mk(OP_CLRK,     C_NEVER, 5'd0,   1'b0);
      5'd16: w = mk(OP_SUB1,     C_LT1,   5'd17,  1'b1);
      5'd17: w = mk(OP_QDIV,     C_NEVER, 5'd0,   1'b0);
      5'd18: w = mk(OP_LEAP,     C_NEVER, 5'd0,   1'b0);
      5'd19: w = mk(OP_MSUB,     C_LTMON, 5'd20,  1'b1);
      5'd20: w = mk(OP_FIN_DATE, C_NEVER, 5'd0,   1'b0);
      // difference: serial number of the other date, subtract
      5'd21: w = mk(OP_SAVE,     C_NEVER, 5'd0,   1'b0);
      5'd22: w = mk(OP_LD_OTHER, C_NEVER, 5'd0,   1'b0);
      5'd23: w = mk(OP_QDIV,     C_NEVER, 5'd0,   1'b0);
      5'd24: w = mk(OP_LEAP,     C_NEVER, 5'd0,   1'b0);
      5'd25: w = mk(OP_MUL365,   C_NEVER, 5'd0,   1'b0);
      5'd26: w = mk(OP_ADDQ,     C_NEVER, 5'd0,   1'b0);
      5'd27: w = mk(OP_MADD,     C_MDONE, 5'd28,  1'b1);
      5'd28: w = mk(OP_DADD,     C_NEVER, 5'd0,   1'b0);
      5'd29: w = mk(OP_SUBS0,    C_NEVER, 5'd0,   1'b0);
      5'd30: w = mk(OP_FIN_DIFF, C_NEVER, 5'd0,   1'b0);
      // bad operand or date out of range
      default: w = mk(OP_FIN_ERR, C_NEVER, 5'd0,  1'b0);
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/cdd_if.sv
// ----------------------------------------------------------------------------
// cdd_in_if / cdd_out_if: request and result channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface cdd_in_if #(parameter int OFFSET_BITS = 16) ();
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic [cdd_pkg::YEAR_W-1:0]          base_year;
  logic [cdd_pkg::MONTH_W-1:0]         base_month;
  logic [cdd_pkg::DAY_W-1:0]           base_day;
  logic signed [OFFSET_BITS-1:0]       day_offset;
  logic [cdd_pkg::YEAR_W-1:0]          other_year;
  logic [cdd_pkg::MONTH_W-1:0]         other_month;
  logic [cdd_pkg::DAY_W-1:0]           other_day;

  modport source (
    output valid, req_type, base_year, base_month, base_day, day_offset,
           other_year, other_month, other_day,
    input  ready
  );
  modport sink (
    input  valid, req_type, base_year, base_month, base_day, day_offset,
           other_year, other_month, other_day,
    output ready
  );
endinterface

interface cdd_out_if ();
  logic                               valid;
  logic                               ready;
  logic [cdd_pkg::YEAR_W-1:0]         result_year;
  logic [cdd_pkg::MONTH_W-1:0]        result_month;
  logic [cdd_pkg::DAY_W-1:0]          result_day;
  logic signed [cdd_pkg::DIFF_W-1:0]  day_difference;
  logic [cdd_pkg::ORDER_W-1:0]        order;
  logic                               error;

  modport source (
    output valid, result_year, result_month, result_day, day_difference, order, error,
    input  ready
  );
  modport sink (
    input  valid, result_year, result_month, result_day, day_difference, order, error,
    output ready
  );
endinterface

FILE: rtl/cdd_seq.sv
// ----------------------------------------------------------------------------
// cdd_seq: microcode sequencer
// Step counter, program ROM and jump condition select. A step whose
// condition holds jumps without running its op; otherwise the op runs and
// the step repeats (loop) or advances.
// ----------------------------------------------------------------------------
module cdd_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              out_busy,
  input  cdd_pkg::flags_t   flags,
  output cdd_pkg::ctrl_t    ctrl,
  output logic              busy
);

  logic [cdd_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                     busy_r, busy_nxt;
  cdd_pkg::uword_t          uw;
  logic                     cond_true;
  logic                     is_fin;
  logic                     step;

  assign uw = cdd_pkg::ucode(pc_r);

  // jump condition select
  always_comb begin
    unique case (uw.cond)
      cdd_pkg::C_NEVER: cond_true = 1'b0;
      cdd_pkg::C_BAD:   cond_true = flags.bad;
      cdd_pkg::C_MDONE: cond_true = flags.mdone;
      cdd_pkg::C_DIFF:  cond_true = flags.diff;
      cdd_pkg::C_RANGE: cond_true = flags.range_err;
      cdd_pkg::C_LT400: cond_true = flags.lt400;
      cdd_pkg::C_LT100: cond_true = flags.lt100;
      cdd_pkg::C_LT4:   cond_true = flags.lt4;
      cdd_pkg::C_LT1:   cond_true = flags.lt1;
      cdd_pkg::C_LTMON: cond_true = flags.ltmon;
      default:          cond_true = 1'b0;
    endcase
  end

  // final steps wait for the output register
  assign is_fin = (uw.op == cdd_pkg::OP_FIN_DATE) || (uw.op == cdd_pkg::OP_FIN_DIFF) ||
                  (uw.op == cdd_pkg::OP_FIN_ERR);
  assign step   = busy_r && !(is_fin && out_busy);

  assign ctrl.exec = step && !cond_true;
  assign ctrl.op   = uw.op;
  assign busy      = busy_r;

  // next step
  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (start) begin
      pc_nxt   = '0;
      busy_nxt = 1'b1;
    end else if (step) begin
      if (cond_true) begin
        pc_nxt = uw.target;
      end else if (!uw.loop) begin
        pc_nxt = pc_r + cdd_pkg::PC_W'(1);
      end
      if (!cond_true && is_fin) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

`ifndef SYNTHESIS
  // every request starts at the head of the program
  a_start_at_head: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> (pc_r == '0))
    else $error("sequencer started away from step zero");

  // a completed final step ends the request
  a_fin_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.exec && is_fin) |=> !busy_r)
    else $error("sequencer still busy after final step");
`endif

endmodule

FILE: rtl/cdd_dp.sv
// ----------------------------------------------------------------------------
// cdd_dp: calendar datapath
// Serial day accumulator, year/month/day registers, one shared multiplier
// and the compare flags that steer the sequencer.
// ----------------------------------------------------------------------------
module cdd_dp #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                          clk,
  input  cdd_pkg::ctrl_t                ctrl,
  input  cdd_pkg::req_t                 req,
  input  logic signed [OFFSET_BITS-1:0] offset,
  output cdd_pkg::flags_t               flags,
  output cdd_pkg::res_t                 res
);

  localparam int SW = ((OFFSET_BITS > cdd_pkg::SERIAL_W) ? OFFSET_BITS
                                                         : cdd_pkg::SERIAL_W) + 2;
  localparam int MUL_W = cdd_pkg::YEAR_W + cdd_pkg::RECIP_W;
  localparam int YW    = cdd_pkg::YEAR_W;

  localparam logic signed [SW-1:0] K_ONE = SW'(1);
  localparam logic signed [SW-1:0] K_400 = SW'(cdd_pkg::DAYS_400);
  localparam logic signed [SW-1:0] K_100 = SW'(cdd_pkg::DAYS_100);
  localparam logic signed [SW-1:0] K_4   = SW'(cdd_pkg::DAYS_4);
  localparam logic signed [SW-1:0] K_1   = SW'(cdd_pkg::DAYS_1);
  localparam logic signed [SW-1:0] K_END = SW'(cdd_pkg::SERIAL_END);

  logic [YW-1:0]                   y_r, y_nxt;
  logic [cdd_pkg::MONTH_W-1:0]     m_r, m_nxt;
  logic [cdd_pkg::DAY_W-1:0]       d_r, d_nxt;
  logic [cdd_pkg::MONTH_W-1:0]     mcnt_r, mcnt_nxt;
  logic [1:0]                      k_r, k_nxt;
  logic [cdd_pkg::Q_W-1:0]         q_r, q_nxt;
  logic [cdd_pkg::Q_W-1:0]         pq_r, pq_nxt;
  logic                            leap_r, leap_nxt;
  logic signed [SW-1:0]            acc_r, acc_nxt;
  logic signed [SW-1:0]            s0_r, s0_nxt;

  logic [YW-1:0]                   ym1;
  logic [YW-1:0]                   mul_a;
  logic [cdd_pkg::RECIP_W-1:0]     mul_b;
  logic [MUL_W-1:0]                prod;
  logic [YW-1:0]                   q100;
  logic                            div100;
  logic [cdd_pkg::DAY_W-1:0]       dim_w;
  logic signed [SW-1:0]            dim_x;
  logic [YW-1:0]                   small_sum;
  logic signed [SW-1:0]            off_x;
  logic signed [SW-1:0]            day_sum;
  logic                            base_bad, other_bad;

  // shared multiplier: year * recip(100) or (year - 1) * 365
  assign ym1   = y_r - YW'(1);
  assign mul_a = (ctrl.op == cdd_pkg::OP_MUL365) ? ym1 : y_r;
  assign mul_b = (ctrl.op == cdd_pkg::OP_MUL365) ? cdd_pkg::RECIP_W'(cdd_pkg::DAYS_1)
                                                 : cdd_pkg::RECIP_W'(cdd_pkg::RECIP_100);
  assign prod  = MUL_W'(mul_a) * MUL_W'(mul_b);

  // century test by shift-add of the quotient
  assign q100   = {q_r, 6'b0} + {1'b0, q_r, 5'b0} + YW'({q_r, 2'b0});
  assign div100 = (y_r == q100);

  assign dim_w = cdd_pkg::month_days(leap_r, mcnt_r);
  assign dim_x = signed'(SW'(dim_w));

  // (y-1)/4 - (y-1)/100 + (y-1)/400
  assign small_sum = YW'(ym1 >> 2) - YW'(pq_r) + YW'(pq_r >> 2);
  assign off_x     = {{(SW - OFFSET_BITS){offset[OFFSET_BITS-1]}}, offset};

  // op decode
  always_comb begin
    y_nxt    = y_r;
    m_nxt    = m_r;
    d_nxt    = d_r;
    mcnt_nxt = mcnt_r;
    k_nxt    = k_r;
    q_nxt    = q_r;
    pq_nxt   = pq_r;
    leap_nxt = leap_r;
    acc_nxt  = acc_r;
    s0_nxt   = s0_r;
    if (ctrl.exec) begin
      unique case (ctrl.op)
        cdd_pkg::OP_LD_BASE: begin
          y_nxt = req.base_year;
          m_nxt = req.base_month;
          d_nxt = req.base_day;
        end
        cdd_pkg::OP_LD_OTHER: begin
          y_nxt = req.other_year;
          m_nxt = req.other_month;
          d_nxt = req.other_day;
        end
        cdd_pkg::OP_QDIV: begin
          q_nxt = prod[cdd_pkg::RECIP_SHIFT +: cdd_pkg::Q_W];
        end
        cdd_pkg::OP_LEAP: begin
          leap_nxt = ((y_r[1:0] == 2'b00) && !div100) || (div100 && (q_r[1:0] == 2'b00));
          pq_nxt   = q_r - cdd_pkg::Q_W'(div100);
          mcnt_nxt = cdd_pkg::MONTH_W'(1);
        end
        cdd_pkg::OP_MUL365: begin
          acc_nxt = signed'(SW'(prod));
        end
        cdd_pkg::OP_ADDQ: begin
          acc_nxt = acc_r + signed'(SW'(small_sum));
        end
        cdd_pkg::OP_MADD: begin
          acc_nxt  = acc_r + dim_x;
          mcnt_nxt = mcnt_r + cdd_pkg::MONTH_W'(1);
        end
        cdd_pkg::OP_DADD: begin
          acc_nxt = acc_r + signed'(SW'(d_r)) - K_ONE;
        end
        cdd_pkg::OP_ADDOFF: begin
          acc_nxt = acc_r + off_x;
        end
        cdd_pkg::OP_INITY: begin
          y_nxt = YW'(1);
          k_nxt = 2'd0;
        end
        cdd_pkg::OP_SUB400: begin
          acc_nxt = acc_r - K_400;
          y_nxt   = y_r + YW'(cdd_pkg::YEARS_400);
        end
        cdd_pkg::OP_SUB100: begin
          acc_nxt = acc_r - K_100;
          y_nxt   = y_r + YW'(cdd_pkg::YEARS_100);
          k_nxt   = k_r + 2'd1;
        end
        cdd_pkg::OP_SUB4: begin
          acc_nxt = acc_r - K_4;
          y_nxt   = y_r + YW'(cdd_pkg::YEARS_4);
        end
        cdd_pkg::OP_CLRK: begin
          k_nxt = 2'd0;
        end
        cdd_pkg::OP_SUB1: begin
          acc_nxt = acc_r - K_1;
          y_nxt   = y_r + YW'(1);
          k_nxt   = k_r + 2'd1;
        end
        cdd_pkg::OP_MSUB: begin
          acc_nxt  = acc_r - dim_x;
          mcnt_nxt = mcnt_r + cdd_pkg::MONTH_W'(1);
        end
        cdd_pkg::OP_SAVE: begin
          // base serial, which is minus one for day zero of the first month
          s0_nxt = acc_r;
        end
        cdd_pkg::OP_SUBS0: begin
          acc_nxt = s0_r - acc_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    y_r    <= y_nxt;
    m_r    <= m_nxt;
    d_r    <= d_nxt;
    mcnt_r <= mcnt_nxt;
    k_r    <= k_nxt;
    q_r    <= q_nxt;
    pq_r   <= pq_nxt;
    leap_r <= leap_nxt;
    acc_r  <= acc_nxt;
    s0_r   <= s0_nxt;
  end

  // operand checks
  assign base_bad  = (req.base_year == '0) || (req.base_year > YW'(cdd_pkg::YEAR_MAX)) ||
                     (req.base_month == '0) ||
                     (req.base_month > cdd_pkg::MONTH_W'(cdd_pkg::MONTHS));
  assign other_bad = (req.other_year == '0) || (req.other_year > YW'(cdd_pkg::YEAR_MAX)) ||
                     (req.other_month == '0) ||
                     (req.other_month > cdd_pkg::MONTH_W'(cdd_pkg::MONTHS));

  // flags for the sequencer
  assign flags.bad       = base_bad || (req.req_type && other_bad);
  assign flags.mdone     = (mcnt_r >= m_r);
  assign flags.diff      = req.req_type;
  assign flags.range_err = acc_r[SW-1] || (acc_r >= K_END);
  assign flags.lt400     = (acc_r < K_400);
  assign flags.lt100     = (acc_r < K_100) || (k_r == 2'd3);
  assign flags.lt4       = (acc_r < K_4);
  assign flags.lt1       = (acc_r < K_1) || (k_r == 2'd3);
  assign flags.ltmon     = (mcnt_r == cdd_pkg::MONTH_W'(cdd_pkg::MONTHS)) || (acc_r < dim_x);

  // results
  assign day_sum   = acc_r + K_ONE;
  assign res.year  = y_r;
  assign res.month = mcnt_r;
  assign res.day   = day_sum[cdd_pkg::DAY_W-1:0];
  assign res.diff  = acc_r[cdd_pkg::DIFF_W-1:0];

endmodule

FILE: rtl/calendar_date_offset_and_difference_unit.sv
// ----------------------------------------------------------------------------
// calendar_date_offset_and_difference_unit: Gregorian date shift and day count
// Run time: the 400-year and 4-year subtract loops of the microcode dominate a
// shift across the whole calendar; a bad operand goes straight to the error step.
// Throughput: one request at a time; the next is taken once the result
// sits in the output register, which holds it until taken.
// Reset: synchronous active-low rst_n clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module calendar_date_offset_and_difference_unit #(
  parameter int OFFSET_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  cdd_in_if.sink     in_ch,
  cdd_out_if.source  out_ch
);

  cdd_pkg::req_t                  req_r;
  logic signed [OFFSET_BITS-1:0]  off_r;
  cdd_pkg::ctrl_t                 ctrl;
  cdd_pkg::flags_t                flags;
  cdd_pkg::res_t                  res;
  logic                           busy;
  logic                           start;
  logic                           fin_exec;

  logic                           out_valid_r, out_valid_nxt;
  logic [cdd_pkg::YEAR_W-1:0]     year_r;
  logic [cdd_pkg::MONTH_W-1:0]    month_r;
  logic [cdd_pkg::DAY_W-1:0]      day_r;
  logic [cdd_pkg::DIFF_W-1:0]     diff_r;
  logic [cdd_pkg::ORDER_W-1:0]    order_r;
  logic                           error_r;
  logic [cdd_pkg::ORDER_W-1:0]    order_w;
  logic [cdd_pkg::YEAR_W+cdd_pkg::MONTH_W+cdd_pkg::DAY_W-1:0] base_key, other_key;

  // request handshake
  assign in_ch.ready = !busy;
  assign start       = in_ch.valid && !busy;

  always_ff @(posedge clk) begin
    if (start) begin
      req_r.req_type    <= in_ch.req_type;
      req_r.base_year   <= in_ch.base_year;
      req_r.base_month  <= in_ch.base_month;
      req_r.base_day    <= in_ch.base_day;
      req_r.other_year  <= in_ch.other_year;
      req_r.other_month <= in_ch.other_month;
      req_r.other_day   <= in_ch.other_day;
      off_r             <= in_ch.day_offset;
    end
  end

  cdd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_busy (out_valid_r && !out_ch.ready),
    .flags    (flags),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  cdd_dp #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk    (clk),
    .ctrl   (ctrl),
    .req    (req_r),
    .offset (off_r),
    .flags  (flags),
    .res    (res)
  );

  // field-by-field order equals order of the packed year/month/day key
  assign base_key  = {req_r.base_year, req_r.base_month, req_r.base_day};
  assign other_key = {req_r.other_year, req_r.other_month, req_r.other_day};
  assign order_w   = (base_key > other_key) ? cdd_pkg::ORDER_GT :
                     (base_key == other_key) ? cdd_pkg::ORDER_EQ : cdd_pkg::ORDER_LT;

  assign fin_exec = ctrl.exec && ((ctrl.op == cdd_pkg::OP_FIN_DATE) ||
                                  (ctrl.op == cdd_pkg::OP_FIN_DIFF) ||
                                  (ctrl.op == cdd_pkg::OP_FIN_ERR));

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fin_exec) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_exec) begin
      order_r <= order_w;
      unique case (ctrl.op)
        cdd_pkg::OP_FIN_DATE: begin
          year_r  <= res.year;
          month_r <= res.month;
          day_r   <= res.day;
          diff_r  <= '0;
          error_r <= 1'b0;
        end
        cdd_pkg::OP_FIN_DIFF: begin
          year_r  <= '0;
          month_r <= '0;
          day_r   <= '0;
          diff_r  <= res.diff;
          error_r <= 1'b0;
        end
        default: begin
          year_r  <= '0;
          month_r <= '0;
          day_r   <= '0;
          diff_r  <= '0;
          error_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_year    = year_r;
  assign out_ch.result_month   = month_r;
  assign out_ch.result_day     = day_r;
  assign out_ch.day_difference = signed'(diff_r);
  assign out_ch.order          = order_r;
  assign out_ch.error          = error_r;

`ifndef SYNTHESIS
  // a waiting result word is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    fin_exec |-> (!out_valid_r || out_ch.ready))
    else $error("result word overwritten while waiting");

  // output valid comes only from a final microcode step
  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fin_exec))
    else $error("result valid without a final step");

  // a completed final step frees the request port for the next request
  a_fin_frees: assert property (@(posedge clk) disable iff (!rst_n)
    fin_exec |=> in_ch.ready)
    else $error("request port not freed after final step");
`endif

endmodule
